[design/esnf_pkg.sv]
`default_nettype none

package esnf_pkg;

	localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

	localparam logic FUNC_ADD_EDGE = 1'b0;
	localparam logic FUNC_RUN      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_RD,
		ST_EDGE_WR,
		ST_ROOT,
		ST_SCAN,
		ST_STK_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic edge_rd;
		logic edge_wr;
		logic root_push;
		logic root_next;
		logic nbr_push;
		logic nbr_skip;
		logic pop;
		logic stk_rd;
		logic abort;
		logic stk_load;
		logic emit_load;
		logic emit_next;
		logic clear_run;
	} cmd_t;

	typedef struct packed {
		logic edge_ok;
		logic root_done;
		logic root_visited;
		logic k_end;
		logic nbr_bit;
		logic nbr_visited;
		logic nbr_on_path;
		logic depth_one;
		logic any_safe;
		logic emit_bit;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[design/esnf_ram.sv]
`default_nettype none

module esnf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/esnf_ctrl.sv]
`default_nettype none

module esnf_ctrl
	import esnf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    func,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = (func == FUNC_RUN) ? ST_ROOT : ST_EDGE_RD;
				end
			end
			ST_EDGE_RD: begin
				if (status.edge_ok) begin
					cmd.edge_rd = 1'b1;
					state_nxt   = ST_EDGE_WR;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EDGE_WR: begin
				cmd.edge_wr = 1'b1;
				state_nxt   = ST_IDLE;
			end
			ST_ROOT: begin
				if (status.root_done) begin
					state_nxt = ST_EMIT;
				end else if (status.root_visited) begin
					cmd.root_next = 1'b1;
				end else begin
					cmd.root_push = 1'b1;
					state_nxt     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.k_end) begin
					cmd.pop = 1'b1;
					if (status.depth_one) begin
						state_nxt = ST_ROOT;
					end else begin
						cmd.stk_rd = 1'b1;
						state_nxt  = ST_STK_RD;
					end
				end else if (status.nbr_bit && !status.nbr_visited) begin
					cmd.nbr_push = 1'b1;
				end else if (status.nbr_bit && status.nbr_on_path) begin
					cmd.abort = 1'b1;
					state_nxt = ST_ROOT;
				end else begin
					cmd.nbr_skip = 1'b1;
				end
			end
			ST_STK_RD: begin
				cmd.stk_load = 1'b1;
				state_nxt    = ST_SCAN;
			end
			ST_EMIT: begin
				if (!status.any_safe) begin
					if (status.out_free) begin
						cmd.emit_load = 1'b1;
						cmd.clear_run = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end else if (!status.emit_bit) begin
					cmd.emit_next = 1'b1;
				end else if (status.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.emit_next = 1'b1;
					if (status.emit_last) begin
						cmd.clear_run = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/esnf_dp.sv]
`default_nettype none

module esnf_dp
	import esnf_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output status_t         status,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data,
	input  wire logic [5:0] edge_source,
	input  wire logic [5:0] edge_target,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic      [5:0] safe_node,
	output logic            last,
	output logic            none_safe
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = NW + CW;

	logic [6:0]           node_count_q;
	logic [5:0]           edge_src_q;
	logic [5:0]           edge_tgt_q;
	logic [MAX_NODES-1:0] row_vld_q;
	logic                 rd_vld_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] on_path_q;
	logic [MAX_NODES-1:0] safe_q;
	logic [NW-1:0]        top_u_q;
	logic [CW-1:0]        top_k_q;
	logic [CW-1:0]        depth_q;
	logic [CW-1:0]        root_q;
	logic [CW-1:0]        emit_q;

	logic [CW-1:0]        n_eff;
	logic [6:0]           n_wide;
	logic [MAX_NODES-1:0] live;
	logic [MAX_NODES-1:0] later;
	logic [MAX_NODES-1:0] tgt_onehot;
	logic [MAX_NODES-1:0] adj_rdata;
	logic [MAX_NODES-1:0] adj_wdata;
	logic [NW-1:0]        adj_raddr;
	logic                 adj_re;
	logic [SW-1:0]        stk_rdata;
	logic [SW-1:0]        stk_wdata;
	logic [CW-1:0]        depth_m1;
	logic [CW-1:0]        depth_m2;
	logic [CW-1:0]        top_k_p1;
	logic [NW-1:0]        stk_u;
	logic [CW-1:0]        stk_k;
	logic [NW-1:0]        src_idx;
	logic [NW-1:0]        k_idx;

	assign n_eff  = (node_count_q > 7'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_q);
	assign n_wide = 7'(n_eff);

	always_comb begin
		tgt_onehot = '0;
		tgt_onehot[edge_tgt_q[NW-1:0]] = 1'b1;
		for (int j = 0; j < MAX_NODES; j++) begin
			live[j]  = CW'(j) < n_eff;
			later[j] = (CW'(j) > emit_q) && live[j];
		end
	end

	assign src_idx  = edge_src_q[NW-1:0];
	assign k_idx    = top_k_q[NW-1:0];
	assign depth_m1 = depth_q - CW'(1);
	assign depth_m2 = depth_q - CW'(2);
	assign top_k_p1 = top_k_q + CW'(1);
	assign stk_u    = stk_rdata[NW-1:0];
	assign stk_k    = stk_rdata[SW-1:NW];
	assign stk_wdata = {top_k_p1, top_u_q};

	always_comb begin
		if (cmd.edge_rd) begin
			adj_raddr = src_idx;
		end else if (cmd.root_push) begin
			adj_raddr = root_q[NW-1:0];
		end else if (cmd.nbr_push) begin
			adj_raddr = k_idx;
		end else begin
			adj_raddr = stk_u;
		end
	end

	assign adj_re    = cmd.edge_rd | cmd.root_push | cmd.nbr_push | cmd.stk_load;
	assign adj_wdata = (rd_vld_q ? adj_rdata : '0) | tgt_onehot;

	esnf_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (cmd.edge_wr),
		.waddr(src_idx),
		.wdata(adj_wdata),
		.re   (adj_re),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	esnf_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_NODES)
	) u_stk_ram (
		.clk  (clk),
		.we   (cmd.nbr_push),
		.waddr(depth_m1[NW-1:0]),
		.wdata(stk_wdata),
		.re   (cmd.stk_rd),
		.raddr(depth_m2[NW-1:0]),
		.rdata(stk_rdata)
	);

	always_comb begin
		status.edge_ok      = ({1'b0, edge_src_q} < n_wide) && ({1'b0, edge_tgt_q} < n_wide);
		status.root_done    = root_q >= n_eff;
		status.root_visited = visited_q[root_q[NW-1:0]];
		status.k_end        = top_k_q >= n_eff;
		status.nbr_bit      = rd_vld_q && adj_rdata[k_idx];
		status.nbr_visited  = visited_q[k_idx];
		status.nbr_on_path  = on_path_q[k_idx];
		status.depth_one    = depth_q == CW'(1);
		status.any_safe     = |(safe_q & live);
		status.emit_bit     = (emit_q < n_eff) && safe_q[emit_q[NW-1:0]];
		status.emit_last    = ~|(safe_q & later);
		status.out_free     = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
			row_vld_q    <= '0;
			rd_vld_q     <= 1'b0;
			visited_q    <= '0;
			on_path_q    <= '0;
			safe_q       <= '0;
			depth_q      <= '0;
			root_q       <= '0;
			emit_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			if (adj_re) begin
				rd_vld_q <= row_vld_q[adj_raddr];
			end
			if (cmd.capture) begin
				root_q <= '0;
				emit_q <= '0;
			end
			if (cmd.edge_wr) begin
				row_vld_q[src_idx] <= 1'b1;
			end
			if (cmd.root_push) begin
				visited_q[root_q[NW-1:0]] <= 1'b1;
				on_path_q[root_q[NW-1:0]] <= 1'b1;
				depth_q <= CW'(1);
			end
			if (cmd.root_next) begin
				root_q <= root_q + CW'(1);
			end
			if (cmd.nbr_push) begin
				visited_q[k_idx] <= 1'b1;
				on_path_q[k_idx] <= 1'b1;
				depth_q <= depth_q + CW'(1);
			end
			if (cmd.pop) begin
				safe_q[top_u_q]    <= 1'b1;
				on_path_q[top_u_q] <= 1'b0;
				depth_q <= depth_m1;
			end
			if (cmd.abort) begin
				depth_q <= '0;
			end
			if (cmd.emit_next) begin
				emit_q <= emit_q + CW'(1);
			end
			if (cmd.emit_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.clear_run) begin
				row_vld_q <= '0;
				visited_q <= '0;
				on_path_q <= '0;
				safe_q    <= '0;
				depth_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			edge_src_q <= edge_source;
			edge_tgt_q <= edge_target;
		end
		if (cmd.root_push) begin
			top_u_q <= root_q[NW-1:0];
			top_k_q <= '0;
		end else if (cmd.nbr_push) begin
			top_u_q <= k_idx;
			top_k_q <= '0;
		end else if (cmd.nbr_skip) begin
			top_k_q <= top_k_p1;
		end else if (cmd.stk_load) begin
			top_u_q <= stk_u;
			top_k_q <= stk_k;
		end
		if (cmd.emit_load) begin
			safe_node <= status.any_safe ? 6'(emit_q) : 6'd0;
			last      <= status.any_safe ? status.emit_last : 1'b1;
			none_safe <= !status.any_safe;
		end
	end

	// A node that has been retired as safe never sits on the current path.
	assert property (@(posedge clk) disable iff (!arst_n) (safe_q & on_path_q) == '0)
		else $error("safe node still marked on path");

	// Every node on the path has been visited.
	assert property (@(posedge clk) disable iff (!arst_n) (on_path_q & ~visited_q) == '0)
		else $error("on-path mark without visited mark");

	// The stack never grows beyond one entry per node.
	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= CW'(MAX_NODES))
		else $error("walk stack overflow");

	// A pop always removes an existing entry.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.pop |-> depth_q != '0)
		else $error("pop from empty walk stack");

endmodule

`default_nettype wire

[design/eventual_safe_node_finder.sv]
// Eventual safe node finder.
// Input channel (in_valid/in_ready) takes one item per transfer. With func low
// the item adds the edge edge_source -> edge_target to the graph; edges with an
// end at or above node_count are dropped. A kept edge reads its source row and
// writes it back with the target bit set; an edge item produces no result. With
// func high the item runs a depth-first search that marks every node from which
// no path reaches a cycle, then streams the safe nodes on the output channel
// (out_valid/out_ready) in ascending order with last set on the final one, or a
// single result with none_safe set.
// A run tests each root, scans the adjacency bits of the node on top of the
// walk stack, pushes unvisited neighbours and pops finished nodes, reloading
// the parent from the walk stack RAM, then steps through node indices up to
// the last safe node while emitting. The walk is bounded by the single read
// port of the adjacency RAM. The graph and all marks are cleared when the last
// result of a run is handed to the output register.
// A stalled receiver holds the output register and pauses emission; edge items
// are accepted again while the final result still waits. Reset empties the
// graph, clears pending output and sets node_count to 64. The user must write
// node_count (cfg_we) only while idle; the block does not enforce it.
`default_nettype none

module eventual_safe_node_finder
	import esnf_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       func,
	input  wire logic [5:0] edge_source,
	input  wire logic [5:0] edge_target,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [5:0] safe_node,
	output logic            last,
	output logic            none_safe
);

	cmd_t    cmd;
	status_t status;

	esnf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	esnf_dp #(
		.MAX_NODES(MAX_NODES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.edge_source(edge_source),
		.edge_target(edge_target),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.safe_node  (safe_node),
		.last       (last),
		.none_safe  (none_safe)
	);

endmodule

`default_nettype wire

[test/esnf_checker.sv]
module esnf_checker
	import esnf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       func,
	input  logic [5:0] edge_source,
	input  logic [5:0] edge_target,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [5:0] safe_node,
	input  logic       last,
	input  logic       none_safe,
	output int         failures,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_NODES = 64;

	typedef struct packed {
		logic [5:0] node;
		logic       last_flag;
		logic       none_flag;
	} safe_report_t;

	safe_report_t expected_safe_nodes[$];
	logic [63:0]  graph_rows[MAX_NODES];
	logic [63:0]  seen_set;
	logic [63:0]  trail_set;
	logic [63:0]  safe_set;
	int           trail_node[MAX_NODES];
	int           trail_next[MAX_NODES];
	int           trail_depth;
	logic [6:0]   node_limit;
	int           fail_count;

	assign failures = fail_count;

	function automatic logic [63:0] lane_mask(input int n);
		if (n >= 64)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	task automatic append_report(input safe_report_t r);
		expected_safe_nodes = {expected_safe_nodes, r};
	endtask

	task automatic clear_graph();
		for (int i = 0; i < MAX_NODES; i++) begin
			graph_rows[i] = '0;
			trail_node[i] = 0;
			trail_next[i] = 0;
		end
		seen_set = '0;
		trail_set = '0;
		safe_set = '0;
		trail_depth = 0;
	endtask

	task automatic push_trail(input int v);
		seen_set[v] = 1'b1;
		trail_set[v] = 1'b1;
		if (trail_depth < MAX_NODES) begin
			trail_node[trail_depth] = v;
			trail_next[trail_depth] = 0;
			trail_depth++;
		end
	endtask

	task automatic walk_from_root(input int root, input logic [63:0] live);
		int top;
		int u;
		int k;
		int j;
		logic [63:0] row;
		push_trail(root);
		while (trail_depth > 0) begin
			top = trail_depth - 1;
			u = trail_node[top];
			k = trail_next[top];
			row = graph_rows[u] & live;
			if (k >= 64)
				row = '0;
			else
				row = row & ~lane_mask(k);
			if (row == '0) begin
				safe_set[u] = 1'b1;
				trail_set[u] = 1'b0;
				trail_depth--;
			end else begin
				j = 0;
				while (!row[j])
					j++;
				trail_next[top] = j + 1;
				if (!seen_set[j])
					push_trail(j);
				else if (trail_set[j])
					trail_depth = 0;
			end
		end
	endtask

	task automatic predict_safe_nodes();
		int n;
		int highest;
		logic [63:0] live;
		safe_report_t r;
		n = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
		live = lane_mask(n);
		for (int i = 0; i < n; i++)
			if (!seen_set[i])
				walk_from_root(i, live);
		highest = -1;
		for (int i = 0; i < n; i++)
			if (safe_set[i] && live[i])
				highest = i;
		if (highest < 0) begin
			r.node = '0;
			r.last_flag = 1'b1;
			r.none_flag = 1'b1;
			append_report(r);
		end else begin
			for (int i = 0; i <= highest; i++) begin
				if (safe_set[i] && live[i]) begin
					r.node = i[5:0];
					r.last_flag = (i == highest);
					r.none_flag = 1'b0;
					append_report(r);
				end
			end
		end
		clear_graph();
	endtask

	always @(posedge clk or negedge arst_n) begin
		safe_report_t want;
		int n;
		if (!arst_n) begin
			clear_graph();
			node_limit = 7'd64;
			expected_safe_nodes.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_safe_nodes.size() == 0) begin
					$error("unexpected result transfer: safe_node %0d last %0b none_safe %0b",
						safe_node, last, none_safe);
					fail_count++;
				end else begin
					want = expected_safe_nodes.pop_front();
					if (safe_node !== want.node) begin
						$error("safe_node: expected %0d, actual %0d", want.node, safe_node);
						fail_count++;
					end
					if (last !== want.last_flag) begin
						$error("last: expected %0b, actual %0b", want.last_flag, last);
						fail_count++;
					end
					if (none_safe !== want.none_flag) begin
						$error("none_safe: expected %0b, actual %0b", want.none_flag, none_safe);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_ADD_EDGE) begin
					n = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
					if (int'(edge_source) < n && int'(edge_target) < n)
						graph_rows[edge_source][edge_target] = 1'b1;
				end else begin
					predict_safe_nodes();
				end
			end
			if (cfg_we)
				node_limit = cfg_data;
		end
		pending = expected_safe_nodes.size();
	end

endmodule

[test/eventual_safe_node_finder_tb.sv]
module eventual_safe_node_finder_tb
	import esnf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LIMIT_CYCLES = 2000000;
	localparam int  HOLD_CYCLES = 500;
	localparam int  SETTLE_CYCLES = 16;
	localparam int  RANDOM_ITEMS = 360;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       func;
	logic [5:0] edge_source;
	logic [5:0] edge_target;
	logic       out_valid;
	logic       out_ready;
	logic [5:0] safe_node;
	logic       last;
	logic       none_safe;
	int         failures;
	int         pending;
	int         cycle_count;
	bit         sender_idles;
	bit         calm;
	bit         hold_request;
	bit         hold_done;

	eventual_safe_node_finder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.edge_source(edge_source),
		.edge_target(edge_target),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.safe_node  (safe_node),
		.last       (last),
		.none_safe  (none_safe)
	);

	esnf_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.edge_source(edge_source),
		.edge_target(edge_target),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.safe_node  (safe_node),
		.last       (last),
		.none_safe  (none_safe),
		.failures   (failures),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done && out_valid) begin
				hold_done = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = calm || ($urandom_range(0, 99) >= 22);
		end
	end

	task automatic send_item(input logic f, input logic [5:0] s, input logic [5:0] t);
		while (sender_idles && !calm && $urandom_range(0, 99) < 22) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		func = f;
		edge_source = s;
		edge_target = t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_node_count(input int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value[6:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic add_edge(input int s, input int t);
		send_item(FUNC_ADD_EDGE, s[5:0], t[5:0]);
	endtask

	task automatic start_run();
		send_item(FUNC_RUN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
	endtask

	initial begin
		int cnt;
		int eff;
		int edges;
		int counted;
		int s;
		int t;
		int pick;
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_ADD_EDGE;
		edge_source = '0;
		edge_target = '0;
		sender_idles = 1'b1;
		calm = 1'b0;
		hold_request = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		start_run();
		add_edge(63, 63);
		add_edge(0, 63);
		add_edge(1, 2);
		add_edge(1, 2);
		start_run();
		wait_idle();
		set_node_count(0);
		add_edge(0, 0);
		start_run();
		wait_idle();
		set_node_count(1);
		start_run();
		add_edge(0, 0);
		start_run();
		wait_idle();
		set_node_count(127);
		add_edge(5, 6);
		add_edge(6, 5);
		add_edge(7, 5);
		add_edge(63, 0);
		start_run();
		wait_idle();
		set_node_count(64);
		add_edge(10, 40);
		add_edge(40, 10);
		add_edge(2, 3);
		add_edge(3, 2);
		add_edge(4, 2);
		wait_idle();
		set_node_count(8);
		add_edge(7, 20);
		start_run();

		cnt = 8;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					cnt = 64;
				else if (pick < 11)
					cnt = $urandom_range(65, 127);
				else if (pick < 13)
					cnt = 0;
				else if (pick < 16)
					cnt = 1;
				else
					cnt = $urandom_range(2, 16);
				wait_idle();
				set_node_count(cnt);
			end
			eff = (cnt > 64) ? 64 : cnt;
			edges = $urandom_range(0, (eff < 10) ? 2 * eff + 2 : 20);
			for (int e = 0; e < edges; e++) begin
				if (eff > 0 && $urandom_range(0, 99) < 88) begin
					s = $urandom_range(0, eff - 1);
					t = $urandom_range(0, eff - 1);
				end else begin
					s = $urandom_range(0, 63);
					t = $urandom_range(0, 63);
				end
				if (s < eff && t < eff)
					counted++;
				add_edge(s, t);
			end
			start_run();
			counted++;
			calm = (counted >= 140 && counted < 220);
			if (!hold_request && counted >= 60) begin
				wait_idle();
				cnt = 64;
				set_node_count(cnt);
				hold_request = 1'b1;
				start_run();
				counted++;
				for (int e = 0; e < 8; e++) begin
					add_edge($urandom_range(0, 63), $urandom_range(0, 63));
					counted++;
				end
			end
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (failures == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
